// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the decimal conversion core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define SITDA_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules clocked by i_clk with reset i_rst_n.
`define SITDA_ASSERT(lbl, prop, msg) \
    `SITDA_ASSERT_CR(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Types and constants of the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int BIN_W   = 32;
    localparam int NDIGITS = 10;
    localparam int BCD_W   = 4 * NDIGITS;
    localparam int STEP_W  = $clog2(BIN_W);
    localparam int NDIG_W  = $clog2(NDIGITS + 1);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // Commands from the sequencer to the shift-and-add unit.
    typedef struct packed {
        logic load;        // take a new magnitude, clear the digit register
        logic step;        // one shift-and-add-3 iteration
        logic digit_shift; // move the digit register up by one decimal digit
    } t_dab_cmd;

endpackage

// ===== rtl/core/sitda_dabble.sv =====
// ----------------------------------------------------------------------------
// sitda_dabble
// Shift-and-add-3 unit that turns a binary magnitude into packed BCD digits.
// ----------------------------------------------------------------------------
module sitda_dabble (
    input  logic                           i_clk,
    input  sitda_pkg::t_dab_cmd            i_cmd,
    input  logic [sitda_pkg::BIN_W-1:0]    i_mag,
    output logic [3:0]                     o_top_digit
);

    logic [sitda_pkg::BIN_W-1:0] r_bin;
    logic [sitda_pkg::BCD_W-1:0] r_bcd;
    logic [sitda_pkg::BCD_W-1:0] w_adj;

    // Every digit of five or more gets three added before it is doubled.
    always_comb begin
        for (int d = 0; d < sitda_pkg::NDIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bcd <= {w_adj[sitda_pkg::BCD_W-2:0], r_bin[sitda_pkg::BIN_W-1]};
            r_bin <= {r_bin[sitda_pkg::BIN_W-2:0], 1'b0};
        end else if (i_cmd.digit_shift) begin
            r_bcd <= {r_bcd[sitda_pkg::BCD_W-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[sitda_pkg::BCD_W-1 -: 4];

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer to decimal ASCII, one character per output transfer.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Handshake
//  s_axis    in   tdata[31:0] = value (signed)              tvalid/tready
//  m_axis    out  tdata[7:0] = out_char, tlast = last       tvalid/tready
//
//  A request is taken in idle; then come 32 shift-and-add-3 steps, leading
//  zeros are dropped one at a time with a step to decide, and the characters
//  go out in turn. A new request is taken only once the last character is
//  loaded. Synchronous active-low reset clears the sequencer and the output
//  valid. A stalled character holds in the output register; the last one
//  may still wait there while a new request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic signed [31:0] i_s_axis_tdata,   // [31:0] value
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [7:0] out_char
    output logic               o_m_axis_tlast    // last
);

    localparam logic [sitda_pkg::STEP_W-1:0] STEP_LAST =
        sitda_pkg::STEP_W'(sitda_pkg::BIN_W - 1);
    localparam logic [sitda_pkg::NDIG_W-1:0] NDIG_FULL =
        sitda_pkg::NDIG_W'(sitda_pkg::NDIGITS);
    localparam logic [sitda_pkg::NDIG_W-1:0] NDIG_ONE =
        sitda_pkg::NDIG_W'(1);

    sitda_pkg::t_state r_state, n_state;
    logic [sitda_pkg::STEP_W-1:0] r_step, n_step;
    logic [sitda_pkg::NDIG_W-1:0] r_ndig, n_ndig;
    logic r_neg, n_neg;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char,  n_out_char;
    logic       r_out_last,  n_out_last;

    sitda_pkg::t_dab_cmd w_cmd;
    logic [31:0] w_raw;
    logic [31:0] w_mag;
    logic [3:0]  w_top_digit;
    logic        w_accept;
    logic        w_can_load;

    // Magnitude taken in unsigned arithmetic, so the most negative value works.
    assign w_raw = $unsigned(i_s_axis_tdata);
    assign w_mag = w_raw[31] ? (32'd0 - w_raw) : w_raw;

    assign o_s_axis_tready = (r_state == sitda_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    // The output register can take a character when empty or being drained.
    assign w_can_load      = !r_out_valid || i_m_axis_tready;

    sitda_dabble u_dabble (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_mag       (w_mag),
        .o_top_digit (w_top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sitda_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_ndig     <= n_ndig;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        w_cmd       = '0;

        unique case (r_state)
            sitda_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    n_neg      = w_raw[31];
                    n_step     = '0;
                    n_state    = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                w_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_ndig  = NDIG_FULL;
                    n_state = sitda_pkg::ST_TRIM;
                end
            end
            sitda_pkg::ST_TRIM: begin
                // Drop leading zeros, but always keep the units digit.
                if (w_top_digit == 4'd0 && r_ndig != NDIG_ONE) begin
                    w_cmd.digit_shift = 1'b1;
                    n_ndig            = r_ndig - 1'b1;
                end else if (r_neg) begin
                    n_state = sitda_pkg::ST_SIGN;
                end else begin
                    n_state = sitda_pkg::ST_DIGITS;
                end
            end
            sitda_pkg::ST_SIGN: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sitda_pkg::CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = sitda_pkg::ST_DIGITS;
                end
            end
            sitda_pkg::ST_DIGITS: begin
                if (w_can_load) begin
                    n_out_valid       = 1'b1;
                    n_out_char        = sitda_pkg::CH_ZERO + {4'd0, w_top_digit};
                    n_out_last        = (r_ndig == NDIG_ONE);
                    w_cmd.digit_shift = 1'b1;
                    n_ndig            = r_ndig - 1'b1;
                    if (r_ndig == NDIG_ONE) begin
                        n_state = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // A sign character is only ever produced for a negative request.
    `SITDA_ASSERT(a_sign_only_neg, ((r_state == sitda_pkg::ST_SIGN) |-> r_neg), "sign without negative input")
    // The digit count stays between one and the full width while emitting.
    `SITDA_ASSERT(a_ndig_range, ((r_state == sitda_pkg::ST_DIGITS) |-> (r_ndig != '0 && r_ndig <= NDIG_FULL)), "digit count out of range")
    // The BCD unit only ever presents a decimal digit at the top.
    `SITDA_ASSERT(a_bcd_digit, ((r_state == sitda_pkg::ST_DIGITS || r_state == sitda_pkg::ST_TRIM) |-> (w_top_digit <= 4'd9)), "top BCD digit above nine")
    // The final digit is marked last and the sequencer returns to idle.
    `SITDA_ASSERT(a_last_done, ((r_state == sitda_pkg::ST_DIGITS && w_can_load && r_ndig == NDIG_ONE) |=> (r_state == sitda_pkg::ST_IDLE && o_m_axis_tvalid && o_m_axis_tlast)), "last digit not marked")

endmodule
